// ===== src/dcv_pkg.sv =====
// ----------------------------------------------------------------------------
// dcv_pkg
// Shared types, widths and tables for the date / day-number converter.
// ----------------------------------------------------------------------------
package dcv_pkg;

  // payload widths
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MON_W   = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned OFF_W   = 23;
  localparam int unsigned COUNT_W = 22;

  // internal widths (sized for the largest supported last year)
  localparam int unsigned YCUR_W = 17;  // working year
  localparam int unsigned DBY_W  = 25;  // days before a year
  localparam int unsigned CNT_W  = 23;  // unsaturated day count of the input date
  localparam int unsigned N_W    = 26;  // shifted day count, two's complement
  localparam int unsigned REM_W  = 9;   // day within a year

  localparam int unsigned MAX_YEAR_DEF = 9999;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;     // capture input transaction, start forward conversion
    logic cnt_en;      // capture day count of the input date
    logic n_en;        // capture shifted day count
    logic y_from_est;  // seed year search from the estimate
    logic y_dec;       // step the working year down
    logic rem_en;      // capture day within year
    logic out_load;    // load the result register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic bad;     // invalid input or shifted count out of range
    logic y_high;  // days before working year exceed shifted count
  } status_t;

  // days in the months before month mon
  function automatic logic [REM_W-1:0] dcv_cum_days(input logic [MON_W-1:0] mon,
                                                    input logic leap);
    logic [REM_W-1:0] base;
    case (mon)
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + ((leap && (mon > 4'd2)) ? 9'd1 : 9'd0);
  endfunction

endpackage

// ===== src/dcv_in_if.sv =====
// ----------------------------------------------------------------------------
// dcv_in_if
// Input channel: date and day offset with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dcv_in_if;
  logic                                valid;
  logic                                ready;
  logic        [dcv_pkg::DAY_W-1:0]    day_in;
  logic        [dcv_pkg::MON_W-1:0]    month_in;
  logic        [dcv_pkg::YEAR_W-1:0]   year_in;
  logic signed [dcv_pkg::OFF_W-1:0]    offset_days;

  modport source (output valid, day_in, month_in, year_in, offset_days, input ready);
  modport sink   (input valid, day_in, month_in, year_in, offset_days, output ready);
endinterface

// ===== src/dcv_out_if.sv =====
// ----------------------------------------------------------------------------
// dcv_out_if
// Result channel: day count, shifted date and flags with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dcv_out_if;
  logic                           valid;
  logic                           ready;
  logic [dcv_pkg::COUNT_W-1:0]    day_count;
  logic [dcv_pkg::DAY_W-1:0]      day_out;
  logic [dcv_pkg::MON_W-1:0]      month_out;
  logic [dcv_pkg::YEAR_W-1:0]     year_out;
  logic                           leap_in;
  logic                           invalid_input;
  logic                           out_of_range;

  modport source (output valid, day_count, day_out, month_out, year_out, leap_in,
                  invalid_input, out_of_range, input ready);
  modport sink   (input valid, day_count, day_out, month_out, year_out, leap_in,
                  invalid_input, out_of_range, output ready);
endinterface

// ===== src/dcv_ctrl.sv =====
// ----------------------------------------------------------------------------
// dcv_ctrl
// Sequencer: forward conversion, year search loop and result hand-off.
// ----------------------------------------------------------------------------
module dcv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  dcv_pkg::status_t  status,
  output dcv_pkg::cmd_t     cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_F1   = 4'd1;
  localparam logic [3:0] S_F2   = 4'd2;
  localparam logic [3:0] S_F3   = 4'd3;
  localparam logic [3:0] S_F4   = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_EST  = 4'd6;
  localparam logic [3:0] S_D1   = 4'd7;
  localparam logic [3:0] S_D2   = 4'd8;
  localparam logic [3:0] S_D3   = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_F1;
        end
      end
      S_F1: state_nxt = S_F2;
      S_F2: state_nxt = S_F3;
      S_F3: begin
        cmd.cnt_en = 1'b1;
        state_nxt  = S_F4;
      end
      S_F4: begin
        cmd.n_en  = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: state_nxt = status.bad ? S_OUT : S_EST;
      S_EST: begin
        cmd.y_from_est = 1'b1;
        state_nxt      = S_D1;
      end
      S_D1: state_nxt = S_D2;
      S_D2: state_nxt = S_D3;
      S_D3: begin
        if (status.y_high) begin
          cmd.y_dec = 1'b1;
          state_nxt = S_D1;
        end else begin
          cmd.rem_en = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  // an accepted transaction always starts the forward conversion
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_F1))
    else $error("accepted transaction did not start conversion");

endmodule

// ===== src/dcv_dpath.sv =====
// ----------------------------------------------------------------------------
// dcv_dpath
// Datapath: shared days-before-year unit, count, shift, year search, month
// decode and the result register.
// ----------------------------------------------------------------------------
module dcv_dpath #(
  parameter int unsigned MAX_YEAR = dcv_pkg::MAX_YEAR_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dcv_pkg::cmd_t                     cmd,
  output dcv_pkg::status_t                  status,
  input  logic        [dcv_pkg::DAY_W-1:0]  day_in,
  input  logic        [dcv_pkg::MON_W-1:0]  month_in,
  input  logic        [dcv_pkg::YEAR_W-1:0] year_in,
  input  logic signed [dcv_pkg::OFF_W-1:0]  offset_days,
  output logic [dcv_pkg::COUNT_W-1:0]       day_count,
  output logic [dcv_pkg::DAY_W-1:0]         day_out,
  output logic [dcv_pkg::MON_W-1:0]         month_out,
  output logic [dcv_pkg::YEAR_W-1:0]        year_out,
  output logic                              leap_in,
  output logic                              invalid_input,
  output logic                              out_of_range
);

  localparam int unsigned YCUR_W  = dcv_pkg::YCUR_W;
  localparam int unsigned DBY_W   = dcv_pkg::DBY_W;
  localparam int unsigned CNT_W   = dcv_pkg::CNT_W;
  localparam int unsigned N_W     = dcv_pkg::N_W;
  localparam int unsigned REM_W   = dcv_pkg::REM_W;
  localparam int unsigned COUNT_W = dcv_pkg::COUNT_W;

  // last valid shifted count: days before the year after the last year, minus one
  localparam int LIMIT_INT = 365 * (MAX_YEAR + 1) + (MAX_YEAR + 4) / 4
                           - (MAX_YEAR + 100) / 100 + (MAX_YEAR + 400) / 400 - 1;
  localparam logic [N_W-1:0] LIMIT = N_W'(LIMIT_INT);

  // reciprocal of the mean year length, scaled by 2^32
  localparam logic [63:0] EST_RECIP_W = (64'd1 << 32) * 64'd400 / 64'd146097;
  localparam logic [23:0] EST_RECIP   = EST_RECIP_W[23:0];

  // reciprocals for division by 100 and 400, exact for operands below 91180
  localparam logic [16:0] DIV_RECIP = 17'd83887;
  localparam int unsigned B_SHIFT   = 23;
  localparam int unsigned C_SHIFT   = 25;

  localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

  // captured transaction
  logic [dcv_pkg::DAY_W-1:0]  d_r;
  logic [dcv_pkg::MON_W-1:0]  m_r;
  logic [dcv_pkg::OFF_W-1:0]  off_r;
  logic                       inv_r;
  logic [YCUR_W-1:0]          y_cur_r, y_cur_nxt;

  // days-before-year unit, product stage
  logic [DBY_W-1:0]   y365_r, y365_nxt;
  logic [15:0]        qa_r, qa_nxt;
  logic [11:0]        qb_r, qb_nxt;
  logic [9:0]         qc_r, qc_nxt;
  logic [YCUR_W-1:0]  yp_r;
  logic [34:0]        b_prod, c_prod;
  logic [17:0]        ya_sum;

  // days-before-year unit, sum stage
  logic [DBY_W-1:0]   dby_r, dby_nxt;
  logic               leap_r, leap_nxt;

  // count, shift, estimate, remainder
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               leap_in_r;
  logic [N_W-1:0]     n_r, n_nxt;
  logic [48:0]        est_r, est_nxt;
  logic [DBY_W-1:0]   rem_full;
  logic [REM_W-1:0]   rem_r;
  logic               oor_w;

  // month decode
  logic [dcv_pkg::MON_W-1:0] mon_sel;
  logic [REM_W-1:0]          day_diff;

  // result register
  logic [COUNT_W-1:0]        count_o_r;
  logic [dcv_pkg::DAY_W-1:0] day_o_r;
  logic [dcv_pkg::MON_W-1:0] mon_o_r;
  logic [dcv_pkg::YEAR_W-1:0] year_o_r;
  logic                      leap_o_r, inv_o_r, oor_o_r;

  // working year: input year, estimate plus two, or one less
  always_comb begin
    y_cur_nxt = y_cur_r;
    if (cmd.load_in) begin
      y_cur_nxt = YCUR_W'(year_in);
    end else if (cmd.y_from_est) begin
      y_cur_nxt = est_r[48:32] + YCUR_W'(2);
    end else if (cmd.y_dec) begin
      y_cur_nxt = y_cur_r - YCUR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    y_cur_r <= y_cur_nxt;
    if (cmd.load_in) begin
      d_r   <= day_in;
      m_r   <= month_in;
      off_r <= offset_days;
      inv_r <= (month_in == 4'd0) || (month_in > 4'd12) || (day_in == 5'd0);
    end
  end

  // product stage: 365*y, (y+3)/4, (y+99)/100, (y+399)/400
  assign ya_sum   = 18'(y_cur_r) + 18'd3;
  assign b_prod   = 35'(18'(y_cur_r) + 18'd99) * 35'(DIV_RECIP);
  assign c_prod   = 35'(18'(y_cur_r) + 18'd399) * 35'(DIV_RECIP);
  assign y365_nxt = DBY_W'(y_cur_r) * DBY_W'(365);
  assign qa_nxt   = ya_sum[17:2];
  assign qb_nxt   = b_prod[B_SHIFT+11:B_SHIFT];
  assign qc_nxt   = c_prod[C_SHIFT+9:C_SHIFT];

  always_ff @(posedge clk) begin
    y365_r <= y365_nxt;
    qa_r   <= qa_nxt;
    qb_r   <= qb_nxt;
    qc_r   <= qc_nxt;
    yp_r   <= y_cur_r;
  end

  // sum stage: days before the year and its leap flag
  always_comb begin
    dby_nxt  = y365_r + DBY_W'(qa_r) - DBY_W'(qb_r) + DBY_W'(qc_r);
    leap_nxt = (yp_r[1:0] == 2'b00) &&
               ((19'(qb_r) * 19'd100 != 19'(yp_r)) || (19'(qc_r) * 19'd400 == 19'(yp_r)));
  end

  always_ff @(posedge clk) begin
    dby_r  <= dby_nxt;
    leap_r <= leap_nxt;
  end

  // day count of the input date and the shifted count
  assign cnt_nxt = dby_r[CNT_W-1:0] + CNT_W'(dcv_pkg::dcv_cum_days(m_r, leap_r))
                 + CNT_W'(d_r) - CNT_W'(1);
  assign n_nxt   = N_W'(cnt_r) + {{(N_W-dcv_pkg::OFF_W){off_r[dcv_pkg::OFF_W-1]}}, off_r};
  assign est_nxt = 49'(n_r[DBY_W-1:0]) * 49'(EST_RECIP);
  assign rem_full = n_r[DBY_W-1:0] - dby_r;

  always_ff @(posedge clk) begin
    est_r <= est_nxt;
    if (cmd.cnt_en) begin
      cnt_r     <= cnt_nxt;
      leap_in_r <= leap_r;
    end
    if (cmd.n_en) begin
      n_r <= n_nxt;
    end
    if (cmd.rem_en) begin
      rem_r <= rem_full[REM_W-1:0];
    end
  end

  // range check of the shifted count
  assign oor_w = n_r[N_W-1] || (n_r > LIMIT);

  assign status.bad    = inv_r || oor_w;
  assign status.y_high = dby_r > n_r[DBY_W-1:0];

  // month and day within the found year
  always_comb begin
    mon_sel = 4'd1;
    for (int i = 2; i <= 12; i++) begin
      if (rem_r >= dcv_pkg::dcv_cum_days(dcv_pkg::MON_W'(i), leap_r)) begin
        mon_sel = dcv_pkg::MON_W'(i);
      end
    end
    day_diff = rem_r - dcv_pkg::dcv_cum_days(mon_sel, leap_r) + REM_W'(1);
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      leap_o_r <= leap_in_r;
      inv_o_r  <= inv_r;
      oor_o_r  <= !inv_r && oor_w;
      if (inv_r) begin
        count_o_r <= '0;
      end else if (cnt_r > CNT_W'(COUNT_SAT)) begin
        count_o_r <= COUNT_SAT;
      end else begin
        count_o_r <= cnt_r[COUNT_W-1:0];
      end
      if (inv_r || oor_w) begin
        day_o_r  <= '0;
        mon_o_r  <= '0;
        year_o_r <= '0;
      end else begin
        day_o_r  <= day_diff[dcv_pkg::DAY_W-1:0];
        mon_o_r  <= mon_sel;
        year_o_r <= y_cur_r[dcv_pkg::YEAR_W-1:0];
      end
    end
  end

  assign day_count     = count_o_r;
  assign day_out       = day_o_r;
  assign month_out     = mon_o_r;
  assign year_out      = year_o_r;
  assign leap_in       = leap_o_r;
  assign invalid_input = inv_o_r;
  assign out_of_range  = oor_o_r;

  // year search only runs on a non-negative count
  a_est_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.y_from_est |-> !n_r[N_W-1])
    else $error("year search started on negative count");

  // the found year must hold the shifted count
  a_rem_in_year: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rem_en |-> (rem_full < DBY_W'(366)))
    else $error("day within year out of range");

  // the search never steps below year zero
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.y_dec |-> (y_cur_r != '0))
    else $error("year search stepped below zero");

endmodule

// ===== src/date_day_number_converter.sv =====
// ----------------------------------------------------------------------------
// date_day_number_converter
// Proleptic Gregorian date to day number, plus the date a signed offset away.
// ----------------------------------------------------------------------------
// One transaction at a time. A valid date passes through the shared
// days-before-year unit (two registered stages) for its day count, which is
// then shifted by the offset, range checked and turned into a year estimate.
// The year search sends the working year through the same unit plus a compare,
// stepping down from its estimate, before the result is loaded. An invalid date
// or an out-of-range shifted date skips the year search. The result register
// lets a new transaction be accepted while the last result waits.
// ----------------------------------------------------------------------------
module date_day_number_converter #(
  parameter int unsigned MAX_YEAR = dcv_pkg::MAX_YEAR_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  dcv_in_if.sink     in_chan,
  dcv_out_if.source  out_chan
);

  dcv_pkg::cmd_t    cmd;
  dcv_pkg::status_t status;

  // sequencer
  dcv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // conversion datapath
  dcv_dpath #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .day_in        (in_chan.day_in),
    .month_in      (in_chan.month_in),
    .year_in       (in_chan.year_in),
    .offset_days   (in_chan.offset_days),
    .day_count     (out_chan.day_count),
    .day_out       (out_chan.day_out),
    .month_out     (out_chan.month_out),
    .year_out      (out_chan.year_out),
    .leap_in       (out_chan.leap_in),
    .invalid_input (out_chan.invalid_input),
    .out_of_range  (out_chan.out_of_range)
  );

endmodule

// ===== bench/date_day_number_converter_test.sv =====
// ----------------------------------------------------------------------------
// date_day_number_converter_test
// Self-checking bench for the date / day-number converter. Dates and day
// offsets go in over the valid/ready input channel; every result transaction
// is checked against a behavioral calendar model kept in this file. The run
// steps through phases of sender gaps and receiver stalls and includes one
// long receiver hold-off while the sender keeps offering dates.
// ----------------------------------------------------------------------------
module date_day_number_converter_test;

  localparam int unsigned DAY_W   = dcv_pkg::DAY_W;
  localparam int unsigned MON_W   = dcv_pkg::MON_W;
  localparam int unsigned YEAR_W  = dcv_pkg::YEAR_W;
  localparam int unsigned OFF_W   = dcv_pkg::OFF_W;
  localparam int unsigned COUNT_W = dcv_pkg::COUNT_W;

  localparam int unsigned LAST_YEAR  = 9999;
  localparam longint     COUNT_SAT  = 4194303;
  localparam int         RAND_DATES = 400;
  localparam int         HOLD_AT    = 40;    // accepted dates before the long hold-off
  localparam int         HOLD_LEN   = 300;   // cycles of receiver hold-off
  localparam int         DRAIN_WAIT = 25;    // a little more than the worst-case latency
  localparam int         PHASE_LEN  = 80;    // dates per idling phase

  // one input transaction
  typedef struct packed {
    logic        [DAY_W-1:0]  day;
    logic        [MON_W-1:0]  month;
    logic        [YEAR_W-1:0] year;
    logic signed [OFF_W-1:0]  offset;
  } date_req_t;

  // one result transaction
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [DAY_W-1:0]   day;
    logic [MON_W-1:0]   month;
    logic [YEAR_W-1:0]  year;
    logic               leap;
    logic               invalid;
    logic               oor;
  } date_res_t;

  // idling modes, selected per phase
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic clk;
  logic rst_n;

  dcv_in_if  in_chan();
  dcv_out_if out_chan();

  date_day_number_converter #(
    .MAX_YEAR (LAST_YEAR)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  date_req_t pending_dates[$];
  date_res_t expected_dates[$];

  int total_dates;
  int sent_total;
  int accepted_total;
  int checked_total;
  int invalid_seen;
  int oor_seen;
  int fault_count;
  int mismatch_count;
  int hold_left;
  bit hold_done;

  // ---------------------------------------------------------------- calendar

  function automatic bit is_leap(longint y);
    if (y % 4 != 0) return 1'b0;
    if (y % 100 != 0) return 1'b1;
    return (y % 400) == 0;
  endfunction

  // days from 1/1/0000 to 1/1 of year y
  function automatic longint days_to_year(longint y);
    return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  function automatic longint month_days(int m, longint y);
    case (m)
      4, 6, 9, 11: return 30;
      2:           return is_leap(y) ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  // day number of a valid-month date, day not clipped to the month length
  function automatic longint day_number(int d, int m, longint y);
    longint cnt;
    cnt = days_to_year(y);
    for (int i = 1; i < m; i++) cnt += month_days(i, y);
    return cnt + d - 1;
  endfunction

  function automatic longint last_day_number();
    return days_to_year(longint'(LAST_YEAR) + 1) - 1;
  endfunction

  // expected result of one date transaction
  function automatic date_res_t convert_date(date_req_t r);
    date_res_t res;
    longint    cnt;
    longint    n;
    longint    yy;
    longint    off;
    int        mon;
    res      = '0;
    res.leap = is_leap(longint'(r.year));
    if (r.month < 1 || r.month > 12 || r.day == 0) begin
      res.invalid = 1'b1;
      return res;
    end
    cnt       = day_number(int'(r.day), int'(r.month), longint'(r.year));
    res.count = (cnt > COUNT_SAT) ? COUNT_W'(COUNT_SAT) : COUNT_W'(cnt);
    off       = {{(64 - OFF_W){r.offset[OFF_W-1]}}, r.offset};
    n         = cnt + off;
    if (n < 0 || n > last_day_number()) begin
      res.oor = 1'b1;
      return res;
    end
    // estimate the year from the mean year length, then settle it
    yy = (n * 400) / 146097;
    while (days_to_year(yy + 1) <= n) yy++;
    while (yy > 0 && days_to_year(yy) > n) yy--;
    n   = n - days_to_year(yy);
    mon = 1;
    while (mon < 12 && n >= month_days(mon, yy)) begin
      n = n - month_days(mon, yy);
      mon++;
    end
    res.day   = DAY_W'(n + 1);
    res.month = MON_W'(mon);
    res.year  = YEAR_W'(yy);
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic date_req_t make_date(int d, int m, int y, longint off);
    date_req_t r;
    r.day    = DAY_W'(d);
    r.month  = MON_W'(m);
    r.year   = YEAR_W'(y);
    r.offset = OFF_W'(off);
    return r;
  endfunction

  // mostly well-formed dates with offsets of every scale, some noise
  function automatic date_req_t random_date();
    date_req_t r;
    int        kind;
    longint    cnt;
    longint    off;
    kind    = $urandom_range(0, 99);
    r.month = MON_W'($urandom_range(1, 12));
    r.year  = ($urandom_range(0, 19) == 0) ? YEAR_W'($urandom_range(10000, 16383))
                                           : YEAR_W'($urandom_range(0, 9999));
    if ($urandom_range(0, 9) == 0)
      r.day = DAY_W'($urandom_range(1, 31));
    else
      r.day = DAY_W'($urandom_range(1, month_days(int'(r.month), longint'(r.year))));
    if (kind < 8) begin
      // bad month or day zero
      r.month = MON_W'($urandom_range(0, 15));
      r.day   = DAY_W'($urandom_range(0, 31));
      if (r.month >= 1 && r.month <= 12) r.day = '0;
      off = longint'($urandom);
    end else if (kind < 40) begin
      off = longint'($urandom_range(0, 3000)) - 1500;
    end else if (kind < 65) begin
      off = longint'($urandom_range(0, 1000000)) - 500000;
    end else if (kind < 85) begin
      off = longint'($urandom);
    end else begin
      // land near the first or the last representable day
      cnt = day_number(int'(r.day), int'(r.month), longint'(r.year));
      off = ($urandom_range(0, 1) == 1) ? last_day_number() - cnt : -cnt;
      off = off + longint'($urandom_range(0, 4)) - 2;
    end
    r.offset = OFF_W'(off);
    return r;
  endfunction

  // ---------------------------------------------------------------- idling

  function automatic idle_mode_t current_mode();
    return idle_mode_t'((sent_total / PHASE_LEN) % 4);
  endfunction

  function automatic bit sender_pauses();
    idle_mode_t mode;
    mode = current_mode();
    if (mode == IDLE_SENDER) return $urandom_range(0, 99) < 58;
    if (mode == IDLE_BOTH) return $urandom_range(0, 99) < 24;
    return 1'b0;
  endfunction

  function automatic bit receiver_stalls();
    idle_mode_t mode;
    mode = current_mode();
    if (mode == IDLE_RECEIVER) return $urandom_range(0, 99) < 58;
    if (mode == IDLE_BOTH) return $urandom_range(0, 99) < 24;
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------- clock

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- input driver

  always @(posedge clk) begin
    date_req_t nxt;
    date_req_t seen;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      // record an accepted transaction and its expected result
      if (in_chan.valid && in_chan.ready) begin
        seen.day    = in_chan.day_in;
        seen.month  = in_chan.month_in;
        seen.year   = in_chan.year_in;
        seen.offset = in_chan.offset_days;
        expected_dates.push_back(convert_date(seen));
        accepted_total++;
      end
      // offer the next date unless one is still held
      if (!in_chan.valid || in_chan.ready) begin
        if (pending_dates.size() != 0 && !sender_pauses()) begin
          nxt = pending_dates.pop_front();
          in_chan.valid       <= 1'b1;
          in_chan.day_in      <= nxt.day;
          in_chan.month_in    <= nxt.month;
          in_chan.year_in     <= nxt.year;
          in_chan.offset_days <= nxt.offset;
          sent_total++;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- long hold-off

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_total >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------- result monitor

  always @(posedge clk) begin
    date_res_t got;
    date_res_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got.count   = out_chan.day_count;
        got.day     = out_chan.day_out;
        got.month   = out_chan.month_out;
        got.year    = out_chan.year_out;
        got.leap    = out_chan.leap_in;
        got.invalid = out_chan.invalid_input;
        got.oor     = out_chan.out_of_range;
        checked_total++;
        if (got.invalid) invalid_seen++;
        if (got.oor) oor_seen++;
        if (expected_dates.size() == 0) begin
          fault_count++;
          $display("unexpected result transaction: count=%0d date=%0d/%0d/%0d",
                   got.count, got.day, got.month, got.year);
        end else begin
          want = expected_dates.pop_front();
          if (got.count !== want.count || got.day !== want.day ||
              got.month !== want.month || got.year !== want.year ||
              got.leap !== want.leap || got.invalid !== want.invalid ||
              got.oor !== want.oor) begin
            fault_count++;
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch on result %0d:", checked_total);
              $display("  expected cnt=%0d %0d/%0d/%0d lp=%0b inv=%0b oor=%0b",
                       want.count, want.day, want.month, want.year,
                       want.leap, want.invalid, want.oor);
              $display("  actual   cnt=%0d %0d/%0d/%0d lp=%0b inv=%0b oor=%0b",
                       got.count, got.day, got.month, got.year,
                       got.leap, got.invalid, got.oor);
            end
          end
        end
      end
      out_chan.ready <= (hold_left == 0) && !receiver_stalls();
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.day_in       = '0;
    in_chan.month_in     = '0;
    in_chan.year_in      = '0;
    in_chan.offset_days  = '0;
    out_chan.ready       = 1'b0;
    sent_total           = 0;
    accepted_total       = 0;
    checked_total        = 0;
    invalid_seen         = 0;
    oor_seen             = 0;
    fault_count          = 0;
    mismatch_count       = 0;

    // directed dates: extremes, leap rules, bad fields, range edges
    pending_dates.push_back(make_date(1, 1, 0, 0));
    pending_dates.push_back(make_date(31, 12, 9999, 0));
    pending_dates.push_back(make_date(31, 12, 9999, 1));
    pending_dates.push_back(make_date(1, 1, 0, -1));
    pending_dates.push_back(make_date(29, 2, 2000, 0));
    pending_dates.push_back(make_date(29, 2, 1900, 0));
    pending_dates.push_back(make_date(28, 2, 2024, 1));
    pending_dates.push_back(make_date(31, 2, 2023, 0));
    pending_dates.push_back(make_date(1, 3, 400, -1));
    pending_dates.push_back(make_date(31, 12, 1999, 1));
    pending_dates.push_back(make_date(15, 0, 2020, 5));
    pending_dates.push_back(make_date(15, 13, 2020, 5));
    pending_dates.push_back(make_date(0, 6, 2020, 5));
    pending_dates.push_back(make_date(31, 15, 16383, -4194304));
    pending_dates.push_back(make_date(1, 1, 0, 4194303));
    pending_dates.push_back(make_date(31, 12, 9999, -4194304));
    pending_dates.push_back(make_date(31, 12, 9999, -last_day_number()));
    pending_dates.push_back(make_date(1, 1, 0, last_day_number()));
    pending_dates.push_back(make_date(31, 12, 16383, -4194304));
    pending_dates.push_back(make_date(31, 12, 16383, 0));
    pending_dates.push_back(make_date(1, 1, 10000, -1));
    pending_dates.push_back(make_date(31, 12, 0, 0));
    pending_dates.push_back(make_date(31, 1, 8191, 4194303));
    for (int i = 0; i < RAND_DATES; i++) pending_dates.push_back(random_date());
    total_dates = pending_dates.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every date to be taken, then for its result
    while (accepted_total < total_dates) @(posedge clk);
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (expected_dates.size() != 0) begin
      fault_count++;
      $display("%0d expected results never arrived", expected_dates.size());
    end
    $display("checked %0d date conversions (%0d invalid dates, %0d shifted out of range)",
             checked_total, invalid_seen, oor_seen);
    $display("idling phases covered sender gaps, receiver stalls and a %0d-cycle hold-off",
             HOLD_LEN);
    if (fault_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------- watchdog

  initial begin
    #5000000;
    $display("timeout waiting for the converter");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/dcv_pkg.sv
src/dcv_in_if.sv
src/dcv_out_if.sv
src/dcv_ctrl.sv
src/dcv_dpath.sv
src/date_day_number_converter.sv
bench/date_day_number_converter_test.sv
